>>> rtl/core/rldu_pkg.sv
// rldu_pkg: shared codes, field widths and the sequencer state type for the
// row list delete/undo block; no dependencies
package rldu_pkg;

  // field widths of the ports
  localparam int CMD_W   = 3;
  localparam int DIST_W  = 10;
  localparam int ROW_W   = 10;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 11;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 1'd1;

  // reset values of the configuration registers
  localparam logic [CNT_W-1:0] ROW_COUNT_RST = 11'd1024;
  localparam logic [ROW_W-1:0] START_ROW_RST = 10'd0;

  // command codes
  localparam logic [CMD_W-1:0] CMD_RESTART = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DOWN    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UP      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RESTORE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_END   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_LAST  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_SWEEP,
    S_WALK,
    S_DEL_A,
    S_DEL_B,
    S_DEL_C,
    S_RES_S,
    S_RES_A,
    S_RES_B,
    S_RES_C,
    S_QRY,
    S_DONE
  } state_t;

endpackage

>>> rtl/core/row_list_delete_undo_unit.sv
// row_list_delete_undo_unit: doubly linked row list with cursor and undo stack
// depends on rldu_pkg and rldu_ram
//
// down/up walks follow one link per cycle through the row ram read port, and
// the restart relink sweep writes one row ram entry a cycle
// one command is worked at a time; the next is taken while a result waits
// reset: synchronous active low; a relink sweep follows
// during which no command is taken (config writes are still taken)
module row_list_delete_undo_unit #(
  parameter int MAX_ROWS = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // command channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rldu_pkg::CMD_W-1:0]      in_command,
  input  logic [rldu_pkg::DIST_W-1:0]     in_distance,
  input  logic [rldu_pkg::ROW_W-1:0]      in_query_row,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rldu_pkg::ROW_W-1:0]      out_cursor_row,
  output logic                            out_row_present,
  output logic [rldu_pkg::STAT_W-1:0]     out_status,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [rldu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rldu_pkg::CFG_W-1:0]      cfg_data
);

  import rldu_pkg::*;

  // row index width, and link width that also holds the null link MAX_ROWS
  localparam int RW = $clog2(MAX_ROWS);
  localparam int LW = RW + 1;
  localparam logic [LW-1:0] NULL_LINK = LW'(MAX_ROWS);

  // one row ram word: present flag plus both links
  typedef struct packed {
    logic          present;
    logic [LW-1:0] prev_link;
    logic [LW-1:0] next_link;
  } row_ent_t;

  localparam int ENT_W = $bits(row_ent_t);

  // configuration registers
  logic [CNT_W-1:0] row_count_r;
  logic [ROW_W-1:0] start_row_r;

  // sequencer state
  state_t            state_r, state_nxt;
  logic [RW-1:0]     cursor_r, cursor_nxt;
  logic [LW-1:0]     rows_used_r, rows_used_nxt;
  logic [LW-1:0]     stk_cnt_r, stk_cnt_nxt;
  logic [DIST_W-1:0] steps_r, steps_nxt;
  logic              dir_up_r, dir_up_nxt;
  logic [LW-1:0]     up_r, up_nxt;
  logic [LW-1:0]     dn_r, dn_nxt;
  logic [RW-1:0]     tgt_r, tgt_nxt;
  logic [RW-1:0]     idx_r, idx_nxt;
  logic              reply_r, reply_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic              present_r, present_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]  out_cursor_r, out_cursor_nxt;
  logic              out_present_r, out_present_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;

  // ram ports
  logic          row_we;
  logic [RW-1:0] row_waddr, row_raddr;
  row_ent_t      row_wdata, row_rd;
  logic [ENT_W-1:0] row_rdata;
  logic          stk_we;
  logic [RW-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;
  logic [LW-1:0] stk_top;

  // restart values: row count clamped to 1..MAX_ROWS, start row to the last row
  logic [31:0] n32;
  logic [31:0] start32;

  assign n32 = (row_count_r == '0) ? 32'd1 :
               (32'(row_count_r) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : 32'(row_count_r);
  assign start32 = (32'(start_row_r) < n32) ? 32'(start_row_r) : n32 - 32'd1;
  assign stk_top = stk_cnt_r - LW'(1);
  assign row_rd  = row_ent_t'(row_rdata);

  function automatic logic is_null(input logic [LW-1:0] lnk);
    return lnk >= NULL_LINK;
  endfunction

  // links, present map: one word per row
  rldu_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_ROWS)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  // stack of deleted rows, never read above the fill count
  rldu_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_ROWS)
  ) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // config registers, written any time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROW_COUNT_RST;
      start_row_r <= START_ROW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_COUNT: row_count_r <= cfg_data;
        CFG_START_ROW: start_row_r <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      reply_r     <= 1'b0;
      stk_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      reply_r     <= reply_nxt;
      stk_cnt_r   <= stk_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers, no reset needed (init state loads what matters)
  always_ff @(posedge clk) begin
    cursor_r      <= cursor_nxt;
    rows_used_r   <= rows_used_nxt;
    steps_r       <= steps_nxt;
    dir_up_r      <= dir_up_nxt;
    up_r          <= up_nxt;
    dn_r          <= dn_nxt;
    tgt_r         <= tgt_nxt;
    idx_r         <= idx_nxt;
    status_r      <= status_nxt;
    present_r     <= present_nxt;
    out_cursor_r  <= out_cursor_nxt;
    out_present_r <= out_present_nxt;
    out_status_r  <= out_status_nxt;
  end

  always_comb begin
    logic [LW-1:0] lnk;
    logic [LW-1:0] up;
    logic [LW-1:0] dn;

    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    rows_used_nxt = rows_used_r;
    stk_cnt_nxt   = stk_cnt_r;
    steps_nxt     = steps_r;
    dir_up_nxt    = dir_up_r;
    up_nxt        = up_r;
    dn_nxt        = dn_r;
    tgt_nxt       = tgt_r;
    idx_nxt       = idx_r;
    reply_nxt     = reply_r;
    status_nxt    = status_r;
    present_nxt   = present_r;

    in_stall  = 1'b1;
    row_we    = 1'b0;
    row_waddr = cursor_r;
    row_wdata = row_rd;
    row_raddr = cursor_r;
    stk_we    = 1'b0;
    stk_waddr = stk_cnt_r[RW-1:0];
    stk_wdata = cursor_r;
    stk_raddr = stk_top[RW-1:0];

    lnk = dir_up_r ? row_rd.prev_link : row_rd.next_link;
    up  = row_rd.prev_link;
    dn  = row_rd.next_link;

    // result word leaves when the consumer takes it
    out_valid_nxt   = out_valid_r && out_stall;
    out_cursor_nxt  = out_cursor_r;
    out_present_nxt = out_present_r;
    out_status_nxt  = out_status_r;

    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          status_nxt  = STAT_OK;
          present_nxt = 1'b0;
          steps_nxt   = in_distance;
          dir_up_nxt  = (in_command == CMD_UP);
          unique case (in_command)
            CMD_RESTART: begin
              reply_nxt = 1'b1;
              state_nxt = S_INIT;
            end
            CMD_DOWN, CMD_UP: begin
              // cursor word is read now, first link is followed next cycle
              state_nxt = (in_distance == '0) ? S_DONE : S_WALK;
            end
            CMD_DELETE: begin
              state_nxt = S_DEL_A;
            end
            CMD_RESTORE: begin
              if (stk_cnt_r == '0) begin
                status_nxt = STAT_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                stk_cnt_nxt = stk_top;
                state_nxt   = S_RES_S;
              end
            end
            CMD_QUERY: begin
              // rows past the ones in use read as absent
              row_raddr = RW'(in_query_row);
              state_nxt = (32'(in_query_row) < 32'(rows_used_r)) ? S_QRY : S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_INIT: begin
        rows_used_nxt = LW'(n32);
        cursor_nxt    = RW'(start32);
        stk_cnt_nxt   = '0;
        idx_nxt       = '0;
        state_nxt     = S_SWEEP;
      end

      S_SWEEP: begin
        // one row relinked per cycle, every row marked present
        row_we              = 1'b1;
        row_waddr           = idx_r;
        row_wdata.present   = 1'b1;
        row_wdata.prev_link = (idx_r == '0) ? NULL_LINK : LW'(idx_r) - LW'(1);
        row_wdata.next_link = (32'(idx_r) + 32'd1 < 32'(rows_used_r)) ?
                              LW'(idx_r) + LW'(1) : NULL_LINK;
        idx_nxt             = idx_r + RW'(1);
        if (32'(idx_r) == 32'(MAX_ROWS - 1)) begin
          state_nxt = reply_r ? S_DONE : S_IDLE;
          reply_nxt = 1'b0;
        end
      end

      S_WALK: begin
        if (is_null(lnk)) begin
          status_nxt = STAT_END;
          state_nxt  = S_DONE;
        end else begin
          cursor_nxt = lnk[RW-1:0];
          steps_nxt  = steps_r - DIST_W'(1);
          row_raddr  = lnk[RW-1:0];
          if (steps_r == DIST_W'(1)) begin
            state_nxt = S_DONE;
          end
        end
      end

      S_DEL_A: begin
        if ((is_null(up) && is_null(dn)) || stk_cnt_r >= NULL_LINK) begin
          status_nxt = STAT_LAST;
          state_nxt  = S_DONE;
        end else begin
          // mark the row deleted, keep its links for a later restore
          row_we            = 1'b1;
          row_waddr         = cursor_r;
          row_wdata.present = 1'b0;
          stk_we            = 1'b1;
          stk_cnt_nxt       = stk_cnt_r + LW'(1);
          up_nxt            = up;
          dn_nxt            = dn;
          cursor_nxt        = is_null(dn) ? up[RW-1:0] : dn[RW-1:0];
          if (!is_null(up)) begin
            row_raddr = up[RW-1:0];
            state_nxt = S_DEL_B;
          end else begin
            row_raddr = dn[RW-1:0];
            state_nxt = S_DEL_C;
          end
        end
      end

      S_DEL_B: begin
        row_we              = 1'b1;
        row_waddr           = up_r[RW-1:0];
        row_wdata.next_link = dn_r;
        if (!is_null(dn_r)) begin
          row_raddr = dn_r[RW-1:0];
          state_nxt = S_DEL_C;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DEL_C: begin
        row_we              = 1'b1;
        row_waddr           = dn_r[RW-1:0];
        row_wdata.prev_link = up_r;
        state_nxt           = S_DONE;
      end

      S_RES_S: begin
        tgt_nxt   = stk_rdata;
        row_raddr = stk_rdata;
        state_nxt = S_RES_A;
      end

      S_RES_A: begin
        row_we            = 1'b1;
        row_waddr         = tgt_r;
        row_wdata.present = 1'b1;
        up_nxt            = up;
        dn_nxt            = dn;
        if (!is_null(up)) begin
          row_raddr = up[RW-1:0];
          state_nxt = S_RES_B;
        end else if (!is_null(dn)) begin
          row_raddr = dn[RW-1:0];
          state_nxt = S_RES_C;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_RES_B: begin
        row_we              = 1'b1;
        row_waddr           = up_r[RW-1:0];
        row_wdata.next_link = LW'(tgt_r);
        if (!is_null(dn_r)) begin
          row_raddr = dn_r[RW-1:0];
          state_nxt = S_RES_C;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_RES_C: begin
        row_we              = 1'b1;
        row_waddr           = dn_r[RW-1:0];
        row_wdata.prev_link = LW'(tgt_r);
        state_nxt           = S_DONE;
      end

      S_QRY: begin
        present_nxt = row_rd.present;
        state_nxt   = S_DONE;
      end

      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_cursor_nxt  = ROW_W'(cursor_r);
          out_present_nxt = present_r;
          out_status_nxt  = status_r;
          state_nxt       = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_cursor_row  = out_cursor_r;
  assign out_row_present = out_present_r;
  assign out_status      = out_status_r;

  // cursor stays on a row in use between commands
  a_cursor_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (LW'(cursor_r) < rows_used_r))
    else $error("cursor outside rows in use");

  // a walk never runs with no steps left
  a_walk_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (steps_r != '0))
    else $error("walk with zero steps");

  // a delete that pushes grows the stack by exactly one
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEL_A && stk_we) |=> (stk_cnt_r == $past(stk_cnt_r) + LW'(1)))
    else $error("stack count not bumped on delete");

  // row ram is left alone while waiting for a command
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !row_we)
    else $error("row write while idle");

  // a result word only appears out of the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result word without a finished command");

endmodule

>>> rtl/core/rldu_ram.sv
// rldu_ram: simple dual port synchronous ram, one write and one registered read
// per cycle; no dependencies
module rldu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> verif/rldu_checker.sv
`timescale 1ns / 1ps
// rldu_checker: watches the command, result and config ports of the row list
// delete/undo block, predicts every result word and compares; uses rldu_pkg
module rldu_checker #(
  parameter int MAX_ROWS = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [rldu_pkg::CMD_W-1:0]      in_command,
  input  logic [rldu_pkg::DIST_W-1:0]     in_distance,
  input  logic [rldu_pkg::ROW_W-1:0]      in_query_row,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [rldu_pkg::ROW_W-1:0]      out_cursor_row,
  input  logic                            out_row_present,
  input  logic [rldu_pkg::STAT_W-1:0]     out_status,
  input  logic                            cfg_we,
  input  logic [rldu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rldu_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            drain_done,
  output int                              fail_count,
  output int                              pending_words,
  output int                              words_checked
);
  import rldu_pkg::*;

  localparam logic [CNT_W-1:0] NULL_LINK = CNT_W'(MAX_ROWS);

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic              row_present;
    logic [STAT_W-1:0] status;
  } row_result_t;

  // own copy of the list state and the registers
  logic [CNT_W-1:0] prev_link [0:MAX_ROWS-1];
  logic [CNT_W-1:0] next_link [0:MAX_ROWS-1];
  logic [ROW_W-1:0] deleted_rows [0:MAX_ROWS-1];
  logic             present_map [0:MAX_ROWS-1];
  int               stack_depth;
  int               rows_used;
  logic [ROW_W-1:0] cursor_q;
  logic [CNT_W-1:0] row_count_q;
  logic [ROW_W-1:0] start_row_q;

  row_result_t expected_rows [$];

  task automatic report_mismatch(input string msg);
    $display("checker: %s", msg);
    fail_count++;
  endtask

  task automatic relink_rows();
    int n;
    n = int'(row_count_q);
    if (n < 1) n = 1;
    if (n > MAX_ROWS) n = MAX_ROWS;
    rows_used = n;
    for (int i = 0; i < MAX_ROWS; i++) begin
      prev_link[i]   = (i == 0) ? NULL_LINK : CNT_W'(i - 1);
      next_link[i]   = (i + 1 < n) ? CNT_W'(i + 1) : NULL_LINK;
      present_map[i] = 1'b1;
    end
    stack_depth = 0;
    cursor_q = (int'(start_row_q) < n) ? start_row_q : ROW_W'(n - 1);
  endtask

  task automatic predict_row_result(input logic [CMD_W-1:0] cmd,
                                    input logic [DIST_W-1:0] walk_len,
                                    input logic [ROW_W-1:0] qrow,
                                    output row_result_t res);
    logic [STAT_W-1:0] st;
    logic              present;
    logic [CNT_W-1:0]  up, dn, nxt;
    logic [ROW_W-1:0]  row;
    st = STAT_OK;
    present = 1'b0;
    case (cmd)
      CMD_RESTART: relink_rows();
      CMD_DOWN, CMD_UP: begin
        for (int i = 0; i < int'(walk_len) && st == STAT_OK; i++) begin
          nxt = (cmd == CMD_DOWN) ? next_link[cursor_q] : prev_link[cursor_q];
          if (nxt >= NULL_LINK) st = STAT_END;
          else cursor_q = nxt[ROW_W-1:0];
        end
      end
      CMD_DELETE: begin
        up = prev_link[cursor_q];
        dn = next_link[cursor_q];
        if ((up >= NULL_LINK && dn >= NULL_LINK) || stack_depth >= MAX_ROWS) begin
          st = STAT_LAST;
        end else begin
          deleted_rows[stack_depth] = cursor_q;
          stack_depth++;
          present_map[cursor_q] = 1'b0;
          if (up < NULL_LINK) next_link[up[ROW_W-1:0]] = dn;
          if (dn < NULL_LINK) prev_link[dn[ROW_W-1:0]] = up;
          cursor_q = (dn < NULL_LINK) ? dn[ROW_W-1:0] : up[ROW_W-1:0];
        end
      end
      CMD_RESTORE: begin
        if (stack_depth == 0) begin
          st = STAT_EMPTY;
        end else begin
          stack_depth--;
          row = deleted_rows[stack_depth];
          up = prev_link[row];
          dn = next_link[row];
          if (up < NULL_LINK) next_link[up[ROW_W-1:0]] = CNT_W'(row);
          if (dn < NULL_LINK) prev_link[dn[ROW_W-1:0]] = CNT_W'(row);
          present_map[row] = 1'b1;
        end
      end
      CMD_QUERY: if (int'(qrow) < rows_used) present = present_map[qrow];
      default: ;
    endcase
    res.cursor_row  = cursor_q;
    res.row_present = present;
    res.status      = st;
  endtask

  always @(posedge clk) begin : watch_ports
    row_result_t got, want;
    if (!rst_n) begin
      row_count_q = ROW_COUNT_RST;
      start_row_q = START_ROW_RST;
      relink_rows();
      expected_rows.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_cursor_row, out_row_present, out_status};
        if (expected_rows.size() == 0) begin
          report_mismatch($sformatf("result word with nothing expected, cursor_row %0d",
                                    got.cursor_row));
        end else begin
          want = expected_rows.pop_front();
          if (got.cursor_row !== want.cursor_row)
            report_mismatch($sformatf("word %0d cursor_row expected %0d got %0d",
                                      words_checked, want.cursor_row, got.cursor_row));
          if (got.row_present !== want.row_present)
            report_mismatch($sformatf("word %0d row_present expected %0d got %0d",
                                      words_checked, want.row_present, got.row_present));
          if (got.status !== want.status)
            report_mismatch($sformatf("word %0d status expected %0d got %0d",
                                      words_checked, want.status, got.status));
          words_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        predict_row_result(in_command, in_distance, in_query_row, want);
        expected_rows = {expected_rows, want};
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROW_COUNT: row_count_q = cfg_data[CNT_W-1:0];
          CFG_START_ROW: start_row_q = cfg_data[ROW_W-1:0];
          default: ;
        endcase
      end
    end
    pending_words = expected_rows.size();
  end

  always @(posedge drain_done) begin
    if (expected_rows.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", expected_rows.size()));
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// tb_top: drives commands and register writes into row_list_delete_undo_unit
// and gives the verdict; uses rldu_pkg and the rldu_checker module
module tb_top;
  import rldu_pkg::*;

  localparam int MAX_ROWS    = 1024;
  localparam int SETUPS      = 8;
  localparam int BURST_WORDS = 158;
  // a restart sweep plus a long receiver stall stays far below this
  localparam int QUIET_LIMIT = 20000;
  // the longest command is the restart sweep
  localparam int TAIL_CYCLES = MAX_ROWS + 64;

  // the two command codes the block does not define
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     in_command = CMD_QUERY;
  logic [DIST_W-1:0]    in_distance = '0;
  logic [ROW_W-1:0]     in_query_row = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ROW_W-1:0]     out_cursor_row;
  logic                 out_row_present;
  logic [STAT_W-1:0]    out_status;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ROW_COUNT;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 drain_done = 1'b0;

  int fail_count;
  int pending_words;
  int words_checked;
  int words_sent;
  int quiet_cycles;
  // idle chances in percent per cycle for each side
  int send_idle_pct;
  int recv_idle_pct;
  // rows in use after the next restart, for aiming queries
  int rows_now = MAX_ROWS;

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  row_list_delete_undo_unit #(.MAX_ROWS(MAX_ROWS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_distance(in_distance), .in_query_row(in_query_row),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_cursor_row(out_cursor_row), .out_row_present(out_row_present),
    .out_status(out_status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rldu_checker #(.MAX_ROWS(MAX_ROWS)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_distance(in_distance), .in_query_row(in_query_row),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_cursor_row(out_cursor_row), .out_row_present(out_row_present),
    .out_status(out_status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .drain_done(drain_done),
    .fail_count(fail_count), .pending_words(pending_words),
    .words_checked(words_checked)
  );

  // receiver side stalls at random, redrawn every falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog: any accepted word on either channel resets the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: no handshake for %0d cycles", quiet_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // one command word: optional idle gap, then hold until taken
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [DIST_W-1:0] walk_len,
                           input logic [ROW_W-1:0] qrow);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_distance  <= walk_len;
    in_query_row <= qrow;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // hold off the sender until every expected result word is back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
  endtask

  // write both registers for list setup k; block is idle here
  task automatic load_setup(input int k);
    logic [CFG_W-1:0] rc, sr;
    case (k)
      1: begin rc = CFG_W'(1); sr = '0; end            // single row
      2: begin rc = 11'h7ff; sr = 11'h7ff; end         // count above max, last row
      3: begin rc = '0; sr = 11'h405; end              // zero count, start clamped
      4: begin rc = CFG_W'(2); sr = CFG_W'(1); end
      5: begin rc = CFG_W'($urandom_range(40, 1)); sr = CFG_W'($urandom_range(2047)); end
      6: begin
        rc = CFG_W'($urandom_range(MAX_ROWS, 1));
        sr = CFG_W'($urandom_range(1023));
      end
      default: begin rc = CFG_W'(16); sr = CFG_W'(3); end
    endcase
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROW_COUNT;
    cfg_data  <= rc;
    @(negedge clk);
    cfg_index <= CFG_START_ROW;
    cfg_data  <= sr;
    @(negedge clk);
    cfg_we    <= 1'b0;
    rows_now = (rc == '0) ? 1 : (int'(rc) > MAX_ROWS) ? MAX_ROWS : int'(rc);
  endtask

  // random commands, mostly list edits and short moves after a restart
  task automatic random_burst(input int n);
    logic [CMD_W-1:0]  cmd;
    logic [DIST_W-1:0] walk_len;
    logic [ROW_W-1:0]  qrow;
    int                pick;
    for (int i = 0; i < n; i++) begin
      // sender waits for an empty pipeline now and then, always mid burst
      if (i == n / 2 || $urandom_range(199) == 0) drain_results();
      pick = $urandom_range(99);
      if (pick < 3)       cmd = CMD_RESTART;
      else if (pick < 23) cmd = CMD_DOWN;
      else if (pick < 43) cmd = CMD_UP;
      else if (pick < 65) cmd = CMD_DELETE;
      else if (pick < 80) cmd = CMD_RESTORE;
      else if (pick < 97) cmd = CMD_QUERY;
      else                cmd = $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;
      // walks cost one cycle per link, so long ones stay rare
      pick = $urandom_range(99);
      if (cmd != CMD_DOWN && cmd != CMD_UP) walk_len = DIST_W'($urandom_range(1023));
      else if (pick < 85)                   walk_len = DIST_W'($urandom_range(7));
      else if (pick < 95)                   walk_len = DIST_W'($urandom_range(63));
      else                                  walk_len = DIST_W'($urandom_range(1023));
      // queries mostly land on rows in use
      if ($urandom_range(99) < 60) qrow = ROW_W'($urandom_range(rows_now - 1));
      else                         qrow = ROW_W'($urandom_range(1023));
      send_word(cmd, walk_len, qrow);
    end
  endtask

  initial begin : stimulus
    // receiver-heavy idling first
    send_idle_pct = 35;
    recv_idle_pct = 58;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed walk over the reset list of MAX_ROWS rows, cursor on row 0
    send_word(CMD_QUERY, 0, 0);
    send_word(CMD_UP, 1, 0);             // move past the first row
    send_word(CMD_RESTORE, 0, 0);        // nothing to restore yet
    send_word(CMD_DOWN, 1023, 1023);     // longest walk, lands on last row
    send_word(CMD_DOWN, 1, 0);           // move past the last row
    send_word(CMD_DELETE, 0, 0);         // last row gone, cursor steps up
    send_word(CMD_QUERY, 0, 1023);
    send_word(CMD_UP, 0, 0);             // zero distance
    send_word(CMD_DELETE, 0, 0);
    send_word(CMD_RESTORE, 0, 0);
    send_word(CMD_RESTORE, 0, 0);
    send_word(CMD_QUERY, 0, 1023);
    send_word(CMD_UP, 1023, 0);          // walk runs off the top
    send_word(CMD_DELETE, 0, 0);         // first row gone, cursor steps down
    send_word(CMD_QUERY, 0, 0);
    send_word(CMD_SPARE_A, 1023, 1023);  // undefined commands change nothing
    send_word(CMD_SPARE_B, 0, 0);
    send_word(CMD_RESTART, 0, 0);
    send_word(CMD_QUERY, 1023, 0);
    random_burst(BURST_WORDS);

    for (int k = 1; k < SETUPS; k++) begin
      drain_results();
      repeat (8) @(negedge clk);
      // sender-heavy idling in the middle setups, none at the end
      if (k == 3) begin
        send_idle_pct = 58;
        recv_idle_pct = 35;
      end else if (k == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      load_setup(k);
      send_word(CMD_RESTART, 0, 0);
      if (k == 1) begin
        // single row: delete refused, row 1 not in use, moves hit both ends
        send_word(CMD_DELETE, 0, 0);
        send_word(CMD_QUERY, 0, 1);
        send_word(CMD_QUERY, 0, 0);
        send_word(CMD_DOWN, 5, 0);
        send_word(CMD_UP, 5, 0);
        send_word(CMD_RESTORE, 0, 0);
      end
      random_burst(BURST_WORDS);
    end

    // let the last results drain, then watch for stray words
    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    drain_done <= 1'b1;
    @(negedge clk);

    $display("tb: %0d command words over %0d list setups, %0d result words checked",
             words_sent, SETUPS, words_checked);
    $display("tb: idle mixes sender-heavy, receiver-heavy and none, %0d mismatches",
             fail_count);
    if (fail_count == 0 && pending_words == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> row_list_delete_undo_unit.f
rtl/core/rldu_pkg.sv
rtl/core/rldu_ram.sv
rtl/core/row_list_delete_undo_unit.sv
verif/rldu_checker.sv
verif/tb_top.sv
